// ===== rtl/dad_pkg.sv =====
// ----------------------------------------------------------------------------
// dad_pkg
// Shared types, constants and the month-length table for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

  // Month codes and calendar constants
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] FEB_LEAP_LEN   = 5'd29;
  localparam logic [4:0] FEB_COMMON_LEN = 5'd28;
  localparam logic [15:0] YEAR_MAX = 16'hFFFF;

  // Reciprocal of 100 scaled by 2^19, rounded down so the estimate never overshoots
  localparam int unsigned RECIP_100_SHIFT = 19;
  localparam logic [12:0] RECIP_100 = 13'd5242;
  localparam logic [7:0]  CENTURY   = 8'd100;
  localparam logic [6:0]  LAST_YEAR_OF_CENTURY = 7'd99;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_WALK,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div;
    logic check;
    logic step;
  } dad_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic bad;
    logic fits;
  } dad_status_t;

  // Length of a month; February follows the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? FEB_LEAP_LEN : FEB_COMMON_LEN;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/date_add_days.sv =====
// ----------------------------------------------------------------------------
// date_add_days
// Adds a day count to a Gregorian date, one month per cycle.
// ----------------------------------------------------------------------------
// Sequence: load, divide for the century counters, check the start date, then
// one month step per month boundary crossed (up to about 2160) and the done
// strobe; an invalid start date skips the walk and goes from the check to done.
// One date at a time: the next start is taken the cycle after done, and
// the month-step loop in the datapath keeps the adder busy while it walks.
// Reset clears the sequencer and the result flags; the result strobe cannot be stalled.
`default_nettype none

module date_add_days
  import dad_pkg::*;
#(
  parameter int unsigned INCREMENT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [15:0] start_year_i,
  input  wire logic [3:0]  start_month_i,
  input  wire logic [4:0]  start_day_i,
  input  wire logic [15:0] days_to_add_i,
  output logic             done_o,
  output logic [15:0]      result_year_o,
  output logic [3:0]       result_month_o,
  output logic [4:0]       result_day_o,
  output logic             year_overflow_o,
  output logic             invalid_start_o
);

  dad_cmd_t    cmd;
  dad_status_t status;

  // Sequencer
  dad_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // Datapath
  dad_datapath #(
    .INCREMENT_BITS (INCREMENT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .start_year_i    (start_year_i),
    .start_month_i   (start_month_i),
    .start_day_i     (start_day_i),
    .days_to_add_i   (days_to_add_i),
    .status_o        (status),
    .result_year_o   (result_year_o),
    .result_month_o  (result_month_o),
    .result_day_o    (result_day_o),
    .year_overflow_o (year_overflow_o),
    .invalid_start_o (invalid_start_o)
  );

endmodule

`default_nettype wire

// ===== rtl/dad_ctrl.sv =====
// ----------------------------------------------------------------------------
// dad_ctrl
// Sequencer for the date adder: prepares the century counters, checks the
// start date, walks one month per cycle for a valid date and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_ctrl
  import dad_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire dad_status_t status_i,
  output dad_cmd_t         cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.bad ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        cmd_o.step = 1'b1;
        if (status_i.fits) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A beat taken in idle starts the preparation
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && state_q == ST_DIV))
    else $error("accepted beat did not start the sequence");

  // The result strobe lasts one cycle and is followed by idle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!done_o && !busy_o))
    else $error("result strobe not a single cycle");

  // The walk is only entered from a check that found a valid date
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && status_i.bad) |=> done_o)
    else $error("invalid start date did not go straight to the result");

endmodule

`default_nettype wire

// ===== rtl/dad_datapath.sv =====
// ----------------------------------------------------------------------------
// dad_datapath
// Date registers, century counters for the leap rule, and the month step.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_datapath
  import dad_pkg::*;
#(
  parameter int unsigned INCREMENT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dad_cmd_t    cmd_i,
  input  wire logic [15:0] start_year_i,
  input  wire logic [3:0]  start_month_i,
  input  wire logic [4:0]  start_day_i,
  input  wire logic [15:0] days_to_add_i,
  output dad_status_t      status_o,
  output logic [15:0]      result_year_o,
  output logic [3:0]       result_month_o,
  output logic [4:0]       result_day_o,
  output logic             year_overflow_o,
  output logic             invalid_start_o
);

  // Step width covers both the day field and the day count, plus a carry
  localparam int unsigned SW = ((INCREMENT_BITS > 5) ? INCREMENT_BITS : 5) + 1;

  logic [15:0]               year_q;
  logic [3:0]                month_q;
  logic [4:0]                day_q;
  logic [INCREMENT_BITS-1:0] inc_q;
  logic [9:0]                cent_est_q;
  logic [6:0]                mod100_q;
  logic [1:0]                cent4_q;
  logic                      ovf_q;
  logic                      bad_q;

  // Trim or widen the day count to the increment width
  logic [INCREMENT_BITS+15:0] inc_ext;
  assign inc_ext = {{INCREMENT_BITS{1'b0}}, days_to_add_i};

  // Century estimate: year * 5242 >> 19 is either floor(year/100) or one less
  logic [28:0] prod;
  assign prod = 29'(year_q) * 29'(RECIP_100);

  // Remainder and one correction step
  logic [16:0] cent_x100;
  logic [16:0] rem_wide;
  logic [7:0]  rem_raw;
  logic        rem_corr;
  logic [6:0]  rem_mod100;
  logic [1:0]  rem_cent4;
  assign cent_x100  = 17'(cent_est_q) * 17'(CENTURY);
  assign rem_wide   = 17'(year_q) - cent_x100;
  assign rem_raw    = rem_wide[7:0];
  assign rem_corr   = rem_raw >= CENTURY;
  assign rem_mod100 = rem_corr ? 7'(rem_raw - CENTURY) : rem_raw[6:0];
  assign rem_cent4  = cent_est_q[1:0] + 2'(rem_corr);

  // Leap flag for the start check and for the walk
  logic leap_chk;
  logic leap_walk;
  assign leap_chk  = (year_q[1:0] == 2'd0) && ((rem_mod100 != 7'd0) || (rem_cent4 == 2'd0));
  assign leap_walk = (year_q[1:0] == 2'd0) && ((mod100_q != 7'd0) || (cent4_q == 2'd0));

  // Start date validity
  logic [4:0] len_chk;
  logic       chk_bad;
  assign len_chk = month_len(month_q, leap_chk);
  assign chk_bad = (month_q < MONTH_JAN) || (month_q > MONTH_DEC) ||
                   (day_q == 5'd0) || (day_q > len_chk);

  // Month step: finish in this month or jump to the first of the next
  logic [4:0]    len_walk;
  logic [SW-1:0] day_sum;
  logic [SW-1:0] skip;
  logic [SW-1:0] inc_left;
  logic          step_fits;
  assign len_walk  = month_len(month_q, leap_walk);
  assign day_sum   = SW'(day_q) + SW'(inc_q);
  assign step_fits = day_sum <= SW'(len_walk);
  assign skip      = SW'(len_walk) - SW'(day_q) + SW'(1);
  assign inc_left  = SW'(inc_q) - skip;

  assign status_o = '{bad: chk_bad, fits: step_fits};

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
      bad_q <= 1'b0;
    end else if (cmd_i.load) begin
      ovf_q <= 1'b0;
      bad_q <= 1'b0;
    end else if (cmd_i.check) begin
      bad_q <= chk_bad;
    end else if (cmd_i.step && !step_fits &&
                 month_q == MONTH_DEC && year_q == YEAR_MAX) begin
      ovf_q <= 1'b1;
    end
  end

  // Date and counter registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      year_q  <= start_year_i;
      month_q <= start_month_i;
      day_q   <= start_day_i;
      inc_q   <= inc_ext[INCREMENT_BITS-1:0];
    end else if (cmd_i.div) begin
      cent_est_q <= prod[RECIP_100_SHIFT+9:RECIP_100_SHIFT];
    end else if (cmd_i.check) begin
      mod100_q <= rem_mod100;
      cent4_q  <= rem_cent4;
    end else if (cmd_i.step) begin
      if (step_fits) begin
        day_q <= day_sum[4:0];
      end else begin
        inc_q <= inc_left[INCREMENT_BITS-1:0];
        day_q <= 5'd1;
        if (month_q == MONTH_DEC) begin
          month_q <= MONTH_JAN;
          // Hold the year at its top value; counters stay with it
          if (year_q != YEAR_MAX) begin
            year_q <= year_q + 16'd1;
            if (mod100_q == LAST_YEAR_OF_CENTURY) begin
              mod100_q <= 7'd0;
              cent4_q  <= cent4_q + 2'd1;
            end else begin
              mod100_q <= mod100_q + 7'd1;
            end
          end
        end else begin
          month_q <= month_q + 4'd1;
        end
      end
    end
  end

  assign result_year_o   = year_q;
  assign result_month_o  = month_q;
  assign result_day_o    = day_q;
  assign year_overflow_o = ovf_q;
  assign invalid_start_o = bad_q;

endmodule

`default_nettype wire

// ===== bench/tb_date_add_days.sv =====
// ----------------------------------------------------------------------------
// tb_date_add_days
// Self-checking bench for the date adder. A queue of start dates (directed
// corner dates first, then mostly valid random dates with some junk mixed in)
// feeds a start/busy driver with random gaps. Each accepted beat is run
// through a month-walking calendar model, and every done strobe is compared
// field by field against the oldest predicted date.
// ----------------------------------------------------------------------------

module tb_date_add_days;
  import dad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned INC_BITS       = 16;
  localparam int unsigned INC_MASK       = (1 << INC_BITS) - 1;
  localparam int unsigned RANDOM_DATES   = 250;
  localparam int unsigned CALM_TAIL      = 40;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  // Month lengths, January in the low slot; February is patched by the leap rule
  localparam logic [11:0][4:0] MONTH_LEN_TAB = {
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
    5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
  };

  typedef struct {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] days;
    int unsigned gap;
    bit          drain;
  } date_req_t;

  typedef struct {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        ovf;
    logic        bad;
  } date_sum_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start_i        = 1'b0;
  logic [15:0] start_year_i   = '0;
  logic [3:0]  start_month_i  = '0;
  logic [4:0]  start_day_i    = '0;
  logic [15:0] days_to_add_i  = '0;
  logic        busy_o;
  logic        done_o;
  logic [15:0] result_year_o;
  logic [3:0]  result_month_o;
  logic [4:0]  result_day_o;
  logic        year_overflow_o;
  logic        invalid_start_o;

  date_req_t   date_reqs_q[$];
  date_sum_t   sums_q[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  date_req_t   next_req;
  int unsigned gap_left;
  bit          loaded = 1'b0;
  bit          go;

  date_add_days #(
    .INCREMENT_BITS(INC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .days_to_add_i  (days_to_add_i),
    .done_o         (done_o),
    .result_year_o  (result_year_o),
    .result_month_o (result_month_o),
    .result_day_o   (result_day_o),
    .year_overflow_o(year_overflow_o),
    .invalid_start_o(invalid_start_o)
  );

  always #5 clk_i = ~clk_i;

  // Gregorian leap rule, year zero included
  function automatic bit leap_year(int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  function automatic int unsigned month_days(int unsigned yr, int unsigned mon);
    if (mon == MONTH_FEB) begin
      return leap_year(yr) ? FEB_LEAP_LEN : FEB_COMMON_LEN;
    end
    return MONTH_LEN_TAB[mon - 1];
  endfunction

  // Walk month by month from the start date to the target date
  function automatic date_sum_t predict_sum(logic [15:0] yr, logic [3:0] mon,
                                            logic [4:0] dy, logic [15:0] add);
    date_sum_t   s;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned left;
    int unsigned len;
    bit          fin;
    y     = yr;
    m     = mon;
    d     = dy;
    left  = add & INC_MASK;
    s.ovf = 1'b0;
    s.bad = 1'b0;
    fin   = 1'b0;
    if (m < MONTH_JAN || m > MONTH_DEC || d == 0 || d > month_days(y, m)) begin
      s.bad = 1'b1;
    end else begin
      while (!fin) begin
        len = month_days(y, m);
        if (d + left <= len) begin
          d   = d + left;
          fin = 1'b1;
        end else begin
          left = left - (len - d + 1);
          d    = 1;
          if (m == MONTH_DEC) begin
            m = MONTH_JAN;
            // hold the year at its ceiling and flag it
            if (y == YEAR_MAX) s.ovf = 1'b1;
            else y++;
          end else begin
            m++;
          end
        end
      end
    end
    s.year  = 16'(y);
    s.month = 4'(m);
    s.day   = 5'(d);
    return s;
  endfunction

  task automatic add_req(int unsigned yr, int unsigned mon, int unsigned dy,
                         int unsigned add, int unsigned gap, bit drain);
    date_req_t r;
    r.year  = 16'(yr);
    r.month = 4'(mon);
    r.day   = 5'(dy);
    r.days  = 16'(add);
    r.gap   = gap;
    r.drain = drain;
    date_reqs_q.push_back(r);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: hold a beat while busy, otherwise predict the accepted one and
  // present the next date after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i  <= 1'b0;
      loaded   = 1'b0;
      gap_left = 0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        sums_q.push_back(predict_sum(start_year_i, start_month_i, start_day_i,
                                     days_to_add_i));
      end
      if (!loaded && date_reqs_q.size() != 0) begin
        next_req = date_reqs_q.pop_front();
        gap_left = next_req.gap;
        loaded   = 1'b1;
      end
      go = 1'b0;
      if (loaded && gap_left != 0) begin
        gap_left--;
      end else if (loaded && (!next_req.drain || sums_q.size() == 0)) begin
        go     = 1'b1;
        loaded = 1'b0;
      end
      start_i <= go;
      if (go) begin
        start_year_i  <= next_req.year;
        start_month_i <= next_req.month;
        start_day_i   <= next_req.day;
        days_to_add_i <= next_req.days;
      end
    end
  end

  // Monitor: match each done strobe against the oldest prediction
  always @(posedge clk_i) begin
    date_sum_t want;
    if (rst_ni && done_o) begin
      if (sums_q.size() == 0) begin
        $display("%0t: unexpected result %0d-%0d-%0d ovf %0b bad %0b", $time,
                 result_year_o, result_month_o, result_day_o, year_overflow_o,
                 invalid_start_o);
        mismatches++;
      end else begin
        want = sums_q.pop_front();
        check_field("result_year", want.year, result_year_o);
        check_field("result_month", want.month, result_month_o);
        check_field("result_day", want.day, result_day_o);
        check_field("year_overflow", want.ovf, year_overflow_o);
        check_field("invalid_start", want.bad, invalid_start_o);
      end
    end
  end

  // Count cycles with no beat in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned yr;
    int unsigned mon;
    int unsigned dy;
    int unsigned add;
    int unsigned gap;

    // Directed corner dates
    add_req(2024, 1, 1, 0, 0, 0);
    add_req(0, 1, 1, 0, 0, 0);
    add_req(0, 2, 29, 0, 0, 0);           // year zero is a leap year
    add_req(1900, 2, 29, 0, 0, 0);        // century, not leap
    add_req(2000, 2, 29, 365, 0, 0);      // 400-year leap
    add_req(2024, 2, 29, 1, 0, 0);
    add_req(2023, 2, 28, 1, 0, 0);
    add_req(2023, 1, 1, 30, 0, 0);        // lands on the month's last day
    add_req(2023, 12, 31, 1, 0, 0);       // year rollover
    add_req(65535, 12, 31, 1, 0, 0);      // year overflow
    add_req(65535, 12, 31, 65535, 0, 0);
    add_req(65535, 1, 1, 364, 0, 0);      // ends right at the top
    add_req(1, 1, 1, 65535, 3, 0);
    add_req(2023, 0, 1, 5, 0, 0);         // month zero
    add_req(2023, 13, 1, 5, 0, 0);
    add_req(2023, 14, 15, 5, 0, 0);
    add_req(65535, 15, 31, 65535, 0, 0);  // all-ones fields, bad month
    add_req(2023, 6, 0, 5, 0, 0);         // day zero
    add_req(2023, 4, 31, 5, 0, 0);        // past the month's length
    add_req(2023, 2, 30, 0, 0, 1);        // wait for an empty pipeline first
    add_req(43690, 10, 21, 21845, 0, 0);
    add_req(21845, 5, 10, 43690, 0, 0);

    // Random dates: mostly valid, a few junk beats
    for (int unsigned i = 0; i < RANDOM_DATES; i++) begin
      if ($urandom_range(0, 19) < 3) begin
        yr  = $urandom_range(0, 65535);
        mon = $urandom_range(0, 15);
        dy  = $urandom_range(0, 31);
        add = $urandom_range(0, 65535);
      end else begin
        case ($urandom_range(0, 7))
          0:       yr = 65535 - $urandom_range(0, 200);
          1:       yr = 100 * $urandom_range(0, 655);
          default: yr = $urandom_range(0, 65535);
        endcase
        mon = $urandom_range(MONTH_JAN, MONTH_DEC);
        dy  = $urandom_range(1, month_days(yr, mon));
        case ($urandom_range(0, 3))
          0:       add = $urandom_range(0, 31);
          1:       add = $urandom_range(0, 400);
          2:       add = $urandom_range(0, 4000);
          default: add = $urandom_range(0, 65535);
        endcase
      end
      // random gaps on some dates, none near the end
      gap = 0;
      if (i < RANDOM_DATES - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
      end
      add_req(yr, mon, dy, add, gap, i == RANDOM_DATES / 2);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (date_reqs_q.size() != 0 || loaded || start_i || sums_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
